>>> rtl/core/assert_macros.svh
// assertion macros shared by the utc to local datetime rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define UTCL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle implies expression in the next
`define UTCL_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

>>> rtl/core/utcl_pkg.sv
// types, constants and calendar functions for the utc to local datetime block
// no dependencies
package utcl_pkg;

   localparam int YEAR_W   = 16;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int OFFSET_W = 11;

   // offset register limits and reset value, minutes
   localparam logic signed [OFFSET_W-1:0] OFFSET_MAX   = 11'sd840;
   localparam logic signed [OFFSET_W-1:0] OFFSET_MIN   = -11'sd840;
   localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 11'sd330;

   localparam logic signed [12:0] MINUTES_PER_DAY = 13'sd1440;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   // reciprocal for exact division by 100 over 16-bit years
   localparam logic [32:0] RECIP_100 = 33'd83887;
   localparam int          SHIFT_100 = 23;

   // reciprocal for exact division by 60 below one day of minutes
   localparam logic [22:0] RECIP_60 = 23'd2185;
   localparam int          SHIFT_60 = 17;

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
   } datetime_type;

   // gregorian leap year without a divider
   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic [32:0] prod;
      logic [9:0]  q;
      logic [16:0] back;
      logic        cent;
      prod = {17'b0, y} * RECIP_100;
      q    = prod[SHIFT_100+9:SHIFT_100];
      back = 17'({7'b0, q} * 17'd100);
      cent = (back == {1'b0, y});
      return cent ? (q[1:0] == 2'b00) : (y[1:0] == 2'b00);
   endfunction

   // days in a month, zero for codes that are not a month
   function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] n;
      unique case (m) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   n = 5'd30;
         MONTH_FEB:                                 n = leap ? 5'd29 : 5'd28;
         default:                                   n = 5'd0;
      endcase
      return n;
   endfunction

endpackage

>>> rtl/core/utcl_if.sv
// valid/ready channel interfaces for the utc to local datetime block
// depends on utcl_pkg for field widths
interface utcl_req_if;
   logic                           valid;
   logic                           ready;
   logic [utcl_pkg::YEAR_W-1:0]    utc_year;
   logic [utcl_pkg::MONTH_W-1:0]   utc_month;
   logic [utcl_pkg::DAY_W-1:0]     utc_day;
   logic [utcl_pkg::HOUR_W-1:0]    utc_hour;
   logic [utcl_pkg::MINUTE_W-1:0]  utc_minute;

   modport source (output valid, utc_year, utc_month, utc_day, utc_hour, utc_minute,
                   input ready);
   modport sink   (input valid, utc_year, utc_month, utc_day, utc_hour, utc_minute,
                   output ready);
endinterface

interface utcl_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [utcl_pkg::YEAR_W-1:0]    local_year;
   logic [utcl_pkg::MONTH_W-1:0]   local_month;
   logic [utcl_pkg::DAY_W-1:0]     local_day;
   logic [utcl_pkg::HOUR_W-1:0]    local_hour;
   logic [utcl_pkg::MINUTE_W-1:0]  local_minute;

   modport source (output valid, local_year, local_month, local_day, local_hour,
                   local_minute, input ready);
   modport sink   (input valid, local_year, local_month, local_day, local_hour,
                   local_minute, output ready);
endinterface

interface utcl_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [utcl_pkg::OFFSET_W-1:0] utc_offset;

   modport source (output valid, utc_offset, input ready);
   modport sink   (input valid, utc_offset, output ready);
endinterface

>>> rtl/core/utcl_csr.sv
// offset register with range check on write
// depends on utcl_pkg, utcl_if and assert_macros.svh
`include "assert_macros.svh"

module utcl_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   utcl_csr_if.sink                             csr,
   output logic signed [utcl_pkg::OFFSET_W-1:0] offset
);

   logic signed [utcl_pkg::OFFSET_W-1:0] offset_ff;
   logic signed [utcl_pkg::OFFSET_W-1:0] offset_in;
   logic                                 wr_ok;

   assign csr.ready = 1'b1;

   // out of range writes leave the register alone
   assign wr_ok = csr.valid && (csr.utc_offset >= utcl_pkg::OFFSET_MIN)
                  && (csr.utc_offset <= utcl_pkg::OFFSET_MAX);

   assign offset_in = wr_ok ? csr.utc_offset : offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= utcl_pkg::OFFSET_RESET;
      end else begin
         offset_ff <= offset_in;
      end
   end

   assign offset = offset_ff;

   `UTCL_ASSERT(a_offset_range, clock, reset, offset_ff >= utcl_pkg::OFFSET_MIN && offset_ff <= utcl_pkg::OFFSET_MAX, "offset register left its range")

endmodule

>>> rtl/core/utcl_calc.sv
// calendar arithmetic: add minute offset, carry or borrow one day
// depends on utcl_pkg
module utcl_calc (
   input  utcl_pkg::datetime_type               utc,
   input  logic signed [utcl_pkg::OFFSET_W-1:0] offset,
   output utcl_pkg::datetime_type               loc
);

   logic [10:0]        hm;
   logic signed [12:0] t_sum;
   logic signed [12:0] t_fix;
   logic [10:0]        t_adj;
   logic               carry;
   logic               borrow;
   logic [22:0]        p60;
   logic [4:0]         hr;
   logic [10:0]        min_full;
   logic               leap;
   logic [4:0]         dim;
   logic [5:0]         d_inc;
   logic [4:0]         m_inc;

   // minute of day plus offset, range -840 .. 2763
   assign hm    = ({6'b0, utc.hour} << 6) - ({6'b0, utc.hour} << 2) + {5'b0, utc.minute};
   assign t_sum = $signed({2'b00, hm}) + $signed({{2{offset[10]}}, offset});

   assign carry  = (t_sum >= utcl_pkg::MINUTES_PER_DAY);
   assign borrow = t_sum[12];

   always_comb begin
      if (carry) begin
         t_fix = t_sum - utcl_pkg::MINUTES_PER_DAY;
      end else if (borrow) begin
         t_fix = t_sum + utcl_pkg::MINUTES_PER_DAY;
      end else begin
         t_fix = t_sum;
      end
   end

   assign t_adj    = t_fix[10:0];
   assign p60      = {12'b0, t_adj} * utcl_pkg::RECIP_60;
   assign hr       = p60[utcl_pkg::SHIFT_60+4:utcl_pkg::SHIFT_60];
   assign min_full = t_adj - ({6'b0, hr} << 6) + ({6'b0, hr} << 2);

   // leap only matters for the unchanged year, so one check suffices
   assign leap  = utcl_pkg::is_leap(utc.year);
   assign dim   = utcl_pkg::month_days(leap, utc.month);
   assign d_inc = {1'b0, utc.day} + 6'd1;
   assign m_inc = {1'b0, utc.month} + 5'd1;

   always_comb begin
      loc        = utc;
      loc.hour   = hr;
      loc.minute = min_full[5:0];
      if (carry) begin
         if (d_inc > {1'b0, dim}) begin
            loc.day = 5'd1;
            if (m_inc > {1'b0, utcl_pkg::MONTH_DEC}) begin
               loc.month = utcl_pkg::MONTH_JAN;
               loc.year  = utc.year + 16'd1;
            end else begin
               loc.month = m_inc[3:0];
            end
         end else begin
            loc.day = d_inc[4:0];
         end
      end else if (borrow) begin
         if (utc.day > 5'd1) begin
            loc.day = utc.day - 5'd1;
         end else if (utc.month > utcl_pkg::MONTH_JAN) begin
            loc.month = utc.month - 4'd1;
            loc.day   = utcl_pkg::month_days(leap, utc.month - 4'd1);
         end else begin
            // year zero stays at zero
            loc.month = utcl_pkg::MONTH_DEC;
            loc.year  = (utc.year != 16'd0) ? utc.year - 16'd1 : 16'd0;
            loc.day   = utcl_pkg::month_days(1'b0, utcl_pkg::MONTH_DEC);
         end
      end
   end

endmodule

>>> rtl/core/utc_to_local_datetime.sv
// top level of the utc to local datetime converter
// depends on utcl_pkg, utcl_if, utcl_csr, utcl_calc and assert_macros.svh
//
// Converts a UTC date and time (year, month, day, hour, minute) to local time by
// adding the signed minute offset held in the csr register (reset +330 minutes,
// writes outside -840..+840 are dropped). At most one day is carried forward or
// borrowed back, with Gregorian month lengths; January 1 of year 0 steps back to
// December 31 of year 0, and December 31 of year 65535 steps on to January 1 of
// year 0. Throughput is one transfer per clock while rsp is not stalled: an item
// is held in the input register, and the calendar logic (a constant-reciprocal
// multiply for the century test and one for the hour split) runs between it
// and the result register, which offers the result on rsp. The result register
// holds a result while rsp is stalled and the input register still takes one
// new request before the input stalls too. Offset writes apply to any item not
// yet in the result register and should be made with the block idle.
`include "assert_macros.svh"

module utc_to_local_datetime (
   input  logic      clock,
   input  logic      reset,
   utcl_req_if.sink  req,
   utcl_rsp_if.source rsp,
   utcl_csr_if.sink  csr
);

   // offset register
   logic signed [utcl_pkg::OFFSET_W-1:0] offset;

   utcl_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr),
      .offset (offset)
   );

   // pipeline control
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   utcl_pkg::datetime_type s1_item_ff;
   utcl_pkg::datetime_type s1_item_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   utcl_pkg::datetime_type rsp_item_ff;
   utcl_pkg::datetime_type rsp_item_in;
   utcl_pkg::datetime_type calc_out;
   logic                   s2_free;
   logic                   s1_move;
   logic                   req_fire;

   // result slot is free when empty or being drained this cycle
   assign s2_free   = !rsp_valid_ff || rsp.ready;
   assign s1_move   = s1_valid_ff && s2_free;
   assign req.ready = !s1_valid_ff || s2_free;
   assign req_fire  = req.valid && req.ready;

   // input register
   always_comb begin
      s1_item_in = s1_item_ff;
      if (req_fire) begin
         s1_item_in.year   = req.utc_year;
         s1_item_in.month  = req.utc_month;
         s1_item_in.day    = req.utc_day;
         s1_item_in.hour   = req.utc_hour;
         s1_item_in.minute = req.utc_minute;
      end
   end

   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // calendar arithmetic between the two registers
   utcl_calc u_calc (
      .utc    (s1_item_ff),
      .offset (offset),
      .loc    (calc_out)
   );

   // result register
   assign rsp_item_in = s1_move ? calc_out : rsp_item_ff;

   always_comb begin
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   // result port
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.local_year   = rsp_item_ff.year;
   assign rsp.local_month  = rsp_item_ff.month;
   assign rsp.local_day    = rsp_item_ff.day;
   assign rsp.local_hour   = rsp_item_ff.hour;
   assign rsp.local_minute = rsp_item_ff.minute;

   `UTCL_ASSERT(a_rsp_time_range, clock, reset, !rsp_valid_ff || (rsp_item_ff.hour < 5'd24 && rsp_item_ff.minute < 6'd60), "local time of day out of range")
   `UTCL_ASSERT_NEXT(a_s1_held, clock, reset, s1_valid_ff && !s2_free, s1_valid_ff && $stable(s1_item_ff), "stalled input item lost or changed")
   `UTCL_ASSERT_NEXT(a_s1_to_rsp, clock, reset, s1_valid_ff && s2_free, rsp_valid_ff, "input item moved but no result offered")

endmodule

>>> tb/sv/utc_to_local_datetime_tb.sv
// self-checking testbench for the utc to local datetime converter
// depends on utcl_pkg, the utcl_if channel interfaces and the utc_to_local_datetime rtl

// keeps the live offset and the queue of local times still owed by the block
class local_time_board;
   utcl_pkg::datetime_type expected_q[$];
   int offset_min;
   int results_checked;
   int bad_results;

   function new();
      offset_min = int'(utcl_pkg::OFFSET_RESET);
      results_checked = 0;
      bad_results = 0;
   endfunction

   // out-of-range writes leave the offset alone
   function void load_offset(logic signed [utcl_pkg::OFFSET_W-1:0] v);
      if (v >= utcl_pkg::OFFSET_MIN && v <= utcl_pkg::OFFSET_MAX) begin
         offset_min = int'(v);
      end
   endfunction

   // zero days for codes that are not a month
   static function int month_length(int y, int m);
      bit leap;
      leap = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         utcl_pkg::MONTH_FEB:   return leap ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   // converts one accepted utc time and queues the local time it must give
   function void note_request(utcl_pkg::datetime_type utc);
      utcl_pkg::datetime_type loc;
      int y, m, d, t, dim;
      y = int'(utc.year);
      m = int'(utc.month);
      d = int'(utc.day);
      t = int'(utc.hour) * 60 + int'(utc.minute) + offset_min;
      if (t >= int'(utcl_pkg::MINUTES_PER_DAY)) begin
         dim = month_length(y, m);
         t -= int'(utcl_pkg::MINUTES_PER_DAY);
         d++;
         if (d > dim) begin
            d = 1;
            m++;
            if (m > 12) begin
               m = int'(utcl_pkg::MONTH_JAN);
               y = (y + 1) & 16'hFFFF;
            end
         end
      end else if (t < 0) begin
         t += int'(utcl_pkg::MINUTES_PER_DAY);
         if (d > 1) begin
            d--;
         end else begin
            if (m > 1) begin
               m--;
            end else begin
               m = int'(utcl_pkg::MONTH_DEC);
               if (y > 0) y--;
            end
            d = month_length(y, m);
         end
      end
      loc.year   = 16'(y);
      loc.month  = 4'(m);
      loc.day    = 5'(d);
      loc.hour   = 5'(t / 60);
      loc.minute = 6'(t % 60);
      expected_q.push_back(loc);
   endfunction

   function void check_result(utcl_pkg::datetime_type got);
      utcl_pkg::datetime_type want;
      if (expected_q.size() == 0) begin
         bad_results++;
         if (bad_results <= 40) $error("result with no conversion pending");
         return;
      end
      want = expected_q.pop_front();
      results_checked++;
      if (got !== want) begin
         bad_results++;
         if (bad_results <= 40) begin
            if (got.year !== want.year)
               $error("local_year: expected %0d, got %0d", want.year, got.year);
            if (got.month !== want.month)
               $error("local_month: expected %0d, got %0d", want.month, got.month);
            if (got.day !== want.day)
               $error("local_day: expected %0d, got %0d", want.day, got.day);
            if (got.hour !== want.hour)
               $error("local_hour: expected %0d, got %0d", want.hour, got.hour);
            if (got.minute !== want.minute)
               $error("local_minute: expected %0d, got %0d", want.minute, got.minute);
         end
      end
   endfunction
endclass

module utc_to_local_datetime_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 150;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 185;

   logic clock = 1'b0;
   logic reset;

   utcl_req_if req_if ();
   utcl_rsp_if rsp_if ();
   utcl_csr_if csr_if ();

   utc_to_local_datetime dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   local_time_board board;

   // knobs and counters used by the sender, the receiver, the phase loop and the run guard
   int idle_pct      = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int requests_sent = 0;
   int offset_writes = 0;
   int cycle_count   = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run guard: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("utc_to_local_datetime_tb: done, errors");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold-off on request from the phase loop
   initial begin : rsp_sink
      int hold_served;
      int stall_left;
      hold_served = 0;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // every result transfer is checked against the oldest pending conversion
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         board.check_result({rsp_if.local_year, rsp_if.local_month, rsp_if.local_day,
                             rsp_if.local_hour, rsp_if.local_minute});
      end
   end

   // offers one utc time and holds it until the transfer; called right after an edge
   task automatic send_request(utcl_pkg::datetime_type u);
      req_if.valid      <= 1'b1;
      req_if.utc_year   <= u.year;
      req_if.utc_month  <= u.month;
      req_if.utc_day    <= u.day;
      req_if.utc_hour   <= u.hour;
      req_if.utc_minute <= u.minute;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      board.note_request(u);
      requests_sent++;
   endtask

   task automatic send_utc(int y, int m, int d, int h, int mi);
      utcl_pkg::datetime_type u;
      u.year   = 16'(y);
      u.month  = 4'(m);
      u.day    = 5'(d);
      u.hour   = 5'(h);
      u.minute = 6'(mi);
      send_request(u);
   endtask

   // offset write; only issued with the block drained
   task automatic write_utc_offset(logic signed [utcl_pkg::OFFSET_W-1:0] v);
      csr_if.valid      <= 1'b1;
      csr_if.utc_offset <= v;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      csr_if.valid <= 1'b0;
      board.load_offset(v);
      offset_writes++;
      // a quiet spell with valid low so back to back writes never drive valid twice in a step
      @(posedge clock);
   endtask

   // stop offering and wait for every owed result, then let the pipe settle
   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (board.expected_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // random utc time biased toward month starts and ends, late and early hours and odd years
   function automatic utcl_pkg::datetime_type random_utc();
      utcl_pkg::datetime_type u;
      int len;
      case ($urandom_range(7))
         0, 1, 2, 3: u.year = 16'($urandom_range(65535));
         4:          u.year = $urandom_range(1) ? 16'hFFFF : 16'h0000;
         5:          u.year = 16'(100 * $urandom_range(655));
         6:          u.year = 16'(4 * $urandom_range(16383));
         default:    u.year = 16'($urandom_range(2100, 1970));
      endcase
      // a tenth of the months are any 4-bit code, including the non-months
      u.month = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(12, 1));
      len = board.month_length(int'(u.year), int'(u.month));
      case ($urandom_range(9))
         0, 1, 2, 3, 4: u.day = (len == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(len, 1));
         5, 6:          u.day = 5'd1;
         7, 8:          u.day = (len == 0) ? 5'($urandom_range(31)) : 5'(len);
         default:       u.day = 5'($urandom_range(31));
      endcase
      case ($urandom_range(9))
         7:       u.hour = 5'd0;
         8:       u.hour = 5'd23;
         9:       u.hour = 5'($urandom_range(31));
         default: u.hour = 5'($urandom_range(23));
      endcase
      case ($urandom_range(9))
         7:       u.minute = 6'd0;
         8:       u.minute = 6'd59;
         9:       u.minute = 6'($urandom_range(63));
         default: u.minute = 6'($urandom_range(59));
      endcase
      return u;
   endfunction

   initial begin : stimulus
      logic signed [utcl_pkg::OFFSET_W-1:0] next_offset;
      bit failed;
      board = new();
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.utc_year   <= '0;
      req_if.utc_month  <= '0;
      req_if.utc_day    <= '0;
      req_if.utc_hour   <= '0;
      req_if.utc_minute <= '0;
      csr_if.valid      <= 1'b0;
      csr_if.utc_offset <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: reset offset of +05:30, carries forward
      send_utc(65535, 12, 31, 23, 59);   // wraps past the last year to year 0
      send_utc(2023, 2, 28, 20, 0);      // plain year, into march
      send_utc(2024, 2, 28, 20, 0);      // leap year, feb 29
      send_utc(1900, 2, 28, 20, 0);      // century, not leap
      send_utc(2000, 2, 28, 20, 0);      // fourth century, leap
      send_utc(0, 0, 5, 22, 0);          // month 0 carries to january 1
      send_utc(7, 13, 1, 22, 0);         // month 13 carries into next year
      send_utc(65535, 15, 9, 23, 0);     // month 15 carry with year wrap
      send_utc(2023, 4, 31, 21, 0);      // day past month end rolls over
      send_utc(2023, 6, 0, 21, 0);       // day 0 steps to day 1
      send_utc(0, 1, 1, 0, 0);           // no carry at all
      send_utc(21845, 11, 30, 31, 63);   // hour and minute above range
      drain_results();

      // directed: largest negative offset, borrows backward
      write_utc_offset(utcl_pkg::OFFSET_MIN);
      send_utc(0, 1, 1, 0, 0);           // borrow at year 0 stays in year 0
      send_utc(2024, 3, 1, 0, 0);
      send_utc(2100, 3, 1, 13, 59);
      send_utc(2000, 3, 1, 0, 0);
      send_utc(300, 0, 1, 0, 0);         // month 0 borrows like january
      send_utc(5, 13, 1, 0, 0);          // month 13 drops to december
      send_utc(5, 14, 1, 0, 0);          // non-month lengths are zero
      send_utc(5, 15, 1, 0, 0);
      send_utc(65535, 1, 1, 0, 0);
      send_utc(2023, 5, 31, 14, 0);      // sum lands exactly on midnight
      drain_results();

      // out-of-range writes must all be dropped
      write_utc_offset(11'sd841);
      write_utc_offset(-11'sd841);
      write_utc_offset(11'sh3FF);
      write_utc_offset(11'sh400);
      write_utc_offset(utcl_pkg::OFFSET_MAX);
      send_utc(65535, 12, 31, 31, 63);
      send_utc(2023, 12, 31, 10, 0);     // sum lands exactly on the next day's midnight
      drain_results();
      write_utc_offset(11'sd0);
      send_utc(1999, 12, 31, 23, 59);
      drain_results();

      // random phases, each with its own offset and idle/stall mix
      for (int p = 0; p < PHASES; p++) begin
         idle_pct = 0;
         stall_pct = 0;
         drain_results();
         case (p)
            0:       next_offset = utcl_pkg::OFFSET_MAX;
            1:       next_offset = utcl_pkg::OFFSET_MIN;
            3, 6:    next_offset = 11'($urandom_range(2047));   // may be out of range
            default: next_offset = 11'(int'($urandom_range(1680)) - 840);
         endcase
         write_utc_offset(next_offset);
         case (p % 4)
            1:       begin idle_pct = 54; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 54; end
            3:       begin idle_pct = 18; stall_pct = 18; end
            default: begin idle_pct = 0;  stall_pct = 0;  end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // each cycle is idle with the phase's odds
            while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
               req_if.valid <= 1'b0;
               @(posedge clock);
            end
            send_request(random_utc());
            // long result hold-off while requests keep coming, so the input backs up
            if (p == 2 && i == 20) hold_requests++;
            // sender pause until the block has emptied
            if (p == 5 && i == 90) drain_results();
         end
      end

      idle_pct = 0;
      stall_pct = 0;
      drain_results();
      repeat (8) @(posedge clock);

      if (board.expected_q.size() != 0)
         $error("%0d local times never came out", board.expected_q.size());
      failed = (board.bad_results != 0) || (board.expected_q.size() != 0);
      $display("utc_to_local_datetime_tb: %0d conversions, %0d results checked, %0d offset writes",
               requests_sent, board.results_checked, offset_writes);
      $display("utc_to_local_datetime_tb: day carries and borrows, leap rules, odd fields, stalls");
      if (!failed) begin
         $display("utc_to_local_datetime_tb: done, clean");
      end else begin
         $display("utc_to_local_datetime_tb: done, errors");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/utcl_pkg.sv
rtl/core/utcl_if.sv
rtl/core/utcl_csr.sv
rtl/core/utcl_calc.sv
rtl/core/utc_to_local_datetime.sv
tb/sv/utc_to_local_datetime_tb.sv
